@@ design/assert_macros.svh @@
// assertion macros shared by the mean filter rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside of reset
`define MF3_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// check on every clock edge, reset included
`define MF3_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

@@ design/mf3_pkg.sv @@
// types and constants of the 3x3 mean filter
// no dependencies
package mf3_pkg;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned ROW_W      = 12;
   localparam int unsigned COL_W      = 10;
   localparam int unsigned WREG_W     = 11;
   localparam int unsigned HREG_W     = 12;
   localparam int unsigned LIM_W      = 13;
   localparam int unsigned CSUM_W     = 10;
   localparam int unsigned SUM_W      = 12;
   localparam int unsigned LINE_W     = 2 * PIX_W;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // floor(x / 9) = (x * 7282) >> 16 for x below 2^12
   localparam int unsigned     RECIP_W    = 13;
   localparam logic [12:0]     DIV9_RECIP = 13'd7282;
   localparam int unsigned     DIV9_SHIFT = 16;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ROW0,
      OP_ROW1,
      OP_BODY,
      OP_DRAIN
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               col_first;
      logic               col_second;
      logic               last_col;
      logic               last_tick;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [PIX_W-1:0]   pixel;
   } item_meta_type;

   typedef struct packed {
      logic [PIX_W-1:0]   value;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               end_of_run;
      logic               end_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         count;
      logic               mean0;
      logic [SUM_W-1:0]   sum;
      rsp_word_type       slot0;
      rsp_word_type       slot1;
   } result_pair_type;

endpackage

@@ design/mf3_if.sv @@
// channel interfaces of the 3x3 mean filter: pixel in, result out, register write
// depends on mf3_pkg
interface mf3_req_if import mf3_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output cmd, output pixel_value, input ready);
   modport sink   (input valid, input cmd, input pixel_value, output ready);
endinterface

interface mf3_rsp_if import mf3_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] filtered_value;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   logic             end_of_run;
   logic             end_of_frame;

   modport source (output valid, output filtered_value, output out_row, output out_col,
                   output end_of_run, output end_of_frame, input ready);
   modport sink   (input valid, input filtered_value, input out_row, input out_col,
                   input end_of_run, input end_of_frame, output ready);
endinterface

interface mf3_csr_if import mf3_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/mf3_line_mem.sv @@
// two line buffers packed side by side in one synchronous ram, one read and one write port
// depends on mf3_pkg
module mf3_line_mem import mf3_pkg::*; #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [LINE_W-1:0] wr_data,
   output logic [LINE_W-1:0] rd_data_ff
);

   // upper line in the high byte, middle line in the low byte
   logic [LINE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ design/mf3_seq.sv @@
// row, column and drain counters; classifies each accepted word and picks the line address
// depends on mf3_pkg, assert_macros.svh
`include "assert_macros.svh"

module mf3_seq import mf3_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned ADDR_W    = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [WREG_W-1:0] width_reg,
   input  logic [HREG_W-1:0] height_reg,
   input  logic              req_fire,
   input  logic              req_cmd,
   input  logic [PIX_W-1:0]  req_pixel,
   output item_meta_type     meta,
   output logic [ADDR_W-1:0] rd_addr
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] drain_ff, drain_in;
   logic              draining_ff, draining_in;

   logic [LIM_W-1:0]  w_last;
   logic [HREG_W-1:0] h_last;
   logic              at_last_col;
   logic              drain_last;
   logic              row_last;

   // clamp the registers to the usable range
   always_comb begin
      if (width_reg < WREG_W'(3)) begin
         w_last = LIM_W'(2);
      end else if (LIM_W'(width_reg) > LIM_W'(MAX_WIDTH)) begin
         w_last = LIM_W'(MAX_WIDTH - 1);
      end else begin
         w_last = LIM_W'(width_reg) - LIM_W'(1);
      end
      if (height_reg < HREG_W'(3)) begin
         h_last = HREG_W'(2);
      end else begin
         h_last = height_reg - HREG_W'(1);
      end
   end

   assign at_last_col = LIM_W'(col_ff) >= w_last;
   assign drain_last  = LIM_W'(drain_ff) >= w_last;
   assign row_last    = row_ff >= h_last;

   always_comb begin
      meta = '0;
      if (req_cmd == CMD_DRAIN) begin
         meta.op = draining_ff ? OP_DRAIN : OP_NONE;
      end else if (draining_ff) begin
         meta.op = OP_NONE;
      end else if (row_ff == '0) begin
         meta.op = OP_ROW0;
      end else if (row_ff == ROW_W'(1)) begin
         meta.op = OP_ROW1;
      end else begin
         meta.op = OP_BODY;
      end
      meta.col_first  = (col_ff == '0);
      meta.col_second = (col_ff == ADDR_W'(1));
      meta.last_col   = at_last_col;
      meta.last_tick  = drain_last;
      meta.row        = (meta.op == OP_BODY) ? row_ff - ROW_W'(1) : row_ff;
      meta.col        = (req_cmd == CMD_DRAIN) ? COL_W'(drain_ff) : COL_W'(col_ff);
      meta.pixel      = req_pixel;
      rd_addr         = (req_cmd == CMD_DRAIN) ? drain_ff : col_ff;
   end

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      if (req_fire) begin
         if (req_cmd == CMD_DRAIN) begin
            if (draining_ff) begin
               if (drain_last) begin
                  draining_in = 1'b0;
                  row_in      = '0;
                  col_in      = '0;
                  drain_in    = '0;
               end else begin
                  drain_in = drain_ff + ADDR_W'(1);
               end
            end
         end else if (!draining_ff) begin
            if (at_last_col) begin
               col_in = '0;
               if (row_last) begin
                  draining_in = 1'b1;
                  drain_in    = '0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
      end
   end

   // leaving the drain always restarts the frame at the origin
   `MF3_ASSERT(drain_exit_restarts, clock, reset,
      $fell(draining_ff) |-> (row_ff == '0 && col_ff == '0 && drain_ff == '0))

endmodule

@@ design/mf3_window.sv @@
// read-modify-write stage: takes the line data, keeps the sliding column sums,
// writes the lines back and forms up to two results per word
// depends on mf3_pkg
module mf3_window import mf3_pkg::*; #(
   parameter int unsigned ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  item_meta_type     meta_in,
   input  logic [ADDR_W-1:0] addr_in,
   input  logic [LINE_W-1:0] rd_data,
   input  logic              s2_take,
   output logic              s1_ready,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [LINE_W-1:0] wr_data,
   output logic              s2_valid_ff,
   output result_pair_type   s2_word_ff
);

   logic              s1_valid_ff;
   item_meta_type     s1_meta_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   // column sums of columns c-2 and c-1, and the middle pixel of column c-1
   logic [CSUM_W-1:0] cs_prev2_ff, cs_prev1_ff;
   logic [PIX_W-1:0]  mid_prev1_ff;

   logic [PIX_W-1:0]  up, mid;
   logic [CSUM_W-1:0] cs_cur;
   logic              is_pixel;
   logic              s2_ready;
   logic              s1_adv;
   rsp_word_type      word_a, word_b;
   result_pair_type   pair;

   assign s2_ready = !s2_valid_ff || s2_take;
   assign s1_adv   = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s1_adv;

   assign up  = rd_data[LINE_W-1:PIX_W];
   assign mid = rd_data[PIX_W-1:0];

   assign cs_cur = CSUM_W'(up) + CSUM_W'(mid) + CSUM_W'(s1_meta_ff.pixel);

   assign is_pixel = (s1_meta_ff.op == OP_ROW0) || (s1_meta_ff.op == OP_ROW1) ||
                     (s1_meta_ff.op == OP_BODY);

   // lines shift down: middle becomes upper, new pixel becomes middle
   assign wr_en   = s1_adv && is_pixel;
   assign wr_addr = s1_addr_ff;
   assign wr_data = {mid, s1_meta_ff.pixel};

   always_comb begin
      word_a       = '0;
      word_a.value = s1_meta_ff.col_second ? mid_prev1_ff : '0;
      word_a.row   = s1_meta_ff.row;
      word_a.col   = s1_meta_ff.col - COL_W'(1);
      word_b       = '0;
      word_b.value = mid;
      word_b.row   = s1_meta_ff.row;
      word_b.col   = s1_meta_ff.col;

      pair     = '0;
      pair.sum = SUM_W'(cs_prev2_ff) + SUM_W'(cs_prev1_ff) + SUM_W'(cs_cur);
      case (s1_meta_ff.op)
         OP_ROW0: begin
            pair.count                  = 2'd1;
            pair.slot0.value            = s1_meta_ff.pixel;
            pair.slot0.row              = s1_meta_ff.row;
            pair.slot0.col              = s1_meta_ff.col;
            pair.slot0.end_of_run       = 1'b1;
         end
         OP_BODY: begin
            // left border at column one, mean further right, right border as extra
            if (!s1_meta_ff.col_first) begin
               pair.mean0            = !s1_meta_ff.col_second;
               pair.slot0            = word_a;
               pair.slot0.end_of_run = !s1_meta_ff.last_col;
               pair.slot1            = word_b;
               pair.slot1.end_of_run = 1'b1;
               pair.count            = s1_meta_ff.last_col ? 2'd2 : 2'd1;
            end else if (s1_meta_ff.last_col) begin
               pair.slot0            = word_b;
               pair.slot0.end_of_run = 1'b1;
               pair.count            = 2'd1;
            end
         end
         OP_DRAIN: begin
            pair.count              = 2'd1;
            pair.slot0              = word_b;
            pair.slot0.end_of_run   = 1'b1;
            pair.slot0.end_of_frame = s1_meta_ff.last_tick;
         end
         default: begin
            pair.count = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         cs_prev2_ff  <= '0;
         cs_prev1_ff  <= '0;
         mid_prev1_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_fire;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_adv;
         end
         if (s1_adv && is_pixel) begin
            cs_prev2_ff  <= cs_prev1_ff;
            cs_prev1_ff  <= cs_cur;
            mid_prev1_ff <= mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meta_ff <= meta_in;
         s1_addr_ff <= addr_in;
      end
      if (s2_ready && s1_adv) begin
         s2_word_ff <= pair;
      end
   end

endmodule

@@ design/mf3_out.sv @@
// divide by nine and the two-slot output register feeding the result channel
// depends on mf3_pkg, mf3_if, assert_macros.svh
`include "assert_macros.svh"

module mf3_out import mf3_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            s2_valid,
   input  result_pair_type s2_word,
   output logic            s2_take,
   mf3_rsp_if.source       rsp_ch
);

   logic [1:0]               out_n_ff, out_n_in;
   rsp_word_type             slot0_ff, slot0_in;
   rsp_word_type             slot1_ff, slot1_in;
   logic [SUM_W+RECIP_W-1:0] prod;
   logic                     rsp_fire;
   logic                     can_load;

   assign prod     = (SUM_W+RECIP_W)'(s2_word.sum) * (SUM_W+RECIP_W)'(DIV9_RECIP);
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign can_load = (out_n_ff == 2'd0) || (out_n_ff == 2'd1 && rsp_fire);
   assign s2_take  = s2_valid && can_load;

   always_comb begin
      out_n_in = out_n_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (s2_take) begin
         out_n_in = s2_word.count;
         slot0_in = s2_word.slot0;
         slot1_in = s2_word.slot1;
         if (s2_word.mean0) begin
            slot0_in.value = prod[DIV9_SHIFT +: PIX_W];
         end
      end else if (rsp_fire) begin
         out_n_in = out_n_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_n_ff <= '0;
      end else begin
         out_n_ff <= out_n_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_ch.valid          = (out_n_ff != 2'd0);
   assign rsp_ch.filtered_value = slot0_ff.value;
   assign rsp_ch.out_row        = slot0_ff.row;
   assign rsp_ch.out_col        = slot0_ff.col;
   assign rsp_ch.end_of_run     = slot0_ff.end_of_run;
   assign rsp_ch.end_of_frame   = slot0_ff.end_of_frame;

   // a new pair never lands on top of two pending words
   `MF3_ASSERT(no_load_when_full, clock, reset, (out_n_ff == 2'd2) |-> !s2_take)

endmodule

@@ design/mean_filter_3x3_unit.sv @@
// top level of the 3x3 mean filter: register file, counters, line ram, window, output
// depends on mf3_pkg, mf3_if, mf3_line_mem, mf3_seq, mf3_window, mf3_out, assert_macros.svh
//
//   channel   dir   payload                                                handshake
//   req_ch    in    cmd, pixel_value                                       valid/ready
//   rsp_ch    out   filtered_value, out_row, out_col, end_of_run,
//                   end_of_frame                                           valid/ready
//   csr_ch    in    index, data (0 image_width, 1 image_height)            valid/ready
//
// one word per clock unless rsp_ch back-pressure stalls the pipe; a last-column word
// gives two results and so holds the output register until both leave
// a result passes the ram read, the column sum and the divide by nine, each registered
// the line ram has one read and one write port; a word that uses its read data
// reads the same entry again only a full line later, so no forwarding path is needed
// synchronous reset clears counters, window sums and valid flags; the line ram
// is not cleared, and no result uses an entry before the frame has written it
// rsp_ch back-pressure stalls the pipe; csr_ch is always ready
`include "assert_macros.svh"

module mean_filter_3x3_unit import mf3_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   mf3_req_if.sink    req_ch,
   mf3_rsp_if.source  rsp_ch,
   mf3_csr_if.sink    csr_ch
);

   localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);

   // configuration registers
   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;

   // input side
   logic              req_fire;
   item_meta_type     meta;
   logic [ADDR_W-1:0] rd_addr;

   // read-modify-write of the line ram
   logic              s1_ready;
   logic [LINE_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINE_W-1:0] wr_data;

   // result pair handoff
   logic              s2_valid;
   result_pair_type   s2_word;
   logic              s2_take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_ch.data[WREG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_ch.data[HREG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a new word enters whenever the read stage is free or moving on
   assign req_ch.ready = s1_ready;
   assign req_fire     = req_ch.valid && s1_ready;

   mf3_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .req_fire   (req_fire),
      .req_cmd    (req_ch.cmd),
      .req_pixel  (req_ch.pixel_value),
      .meta       (meta),
      .rd_addr    (rd_addr)
   );

   // line ram read is launched with the accepted word
   mf3_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_mem (
      .clock      (clock),
      .rd_en      (req_fire),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_data_ff (rd_data)
   );

   mf3_window #(
      .ADDR_W (ADDR_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .meta_in     (meta),
      .addr_in     (rd_addr),
      .rd_data     (rd_data),
      .s2_take     (s2_take),
      .s1_ready    (s1_ready),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .s2_valid_ff (s2_valid),
      .s2_word_ff  (s2_word)
   );

   mf3_out u_out (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_word  (s2_word),
      .s2_take  (s2_take),
      .rsp_ch   (rsp_ch)
   );

   // write-back and the next read that is used never hit the same line entry
   // (ignored words read a don't-care address)
   `MF3_ASSERT(ram_no_collision, clock, reset, (wr_en && req_fire && meta.op != OP_NONE) |-> (wr_addr != rd_addr))

   // the write-back only happens while a word moves out of the read stage
   `MF3_ASSERT(write_needs_room, clock, reset, wr_en |-> s1_ready)

endmodule
